// ===== design/rv32ex_pkg.sv =====
// rv32ex_pkg: shared types and constants for the rv32i execute stage
// transfer payload structs, instruction format codes, funct3 codes, datapath selects
// no dependencies

package rv32ex_pkg;

    // field widths fixed by the instruction transfer format
    localparam int XLEN      = 32;
    localparam int PC_BITS   = 16;
    localparam int IMM_BITS  = 20;

    // default width of code addresses (wrap point of pc arithmetic)
    localparam int CODE_ADDR_BITS_DEFAULT = 16;

    // fixed constants of the instruction set
    localparam logic [XLEN-1:0] JALR_ALIGN_MASK = 32'hffff_fffe;
    localparam int              UPPER_SHIFT     = 12;
    localparam logic [XLEN-1:0] INSTR_BYTES     = 32'd4;

    // instruction format codes
    localparam logic [2:0] KIND_R     = 3'd0;
    localparam logic [2:0] KIND_I     = 3'd1;
    localparam logic [2:0] KIND_S     = 3'd2;
    localparam logic [2:0] KIND_B     = 3'd3;
    localparam logic [2:0] KIND_U     = 3'd4;
    localparam logic [2:0] KIND_J     = 3'd5;

    // alu funct3 codes
    localparam logic [2:0] F3_ADD     = 3'd0;
    localparam logic [2:0] F3_SLL     = 3'd1;
    localparam logic [2:0] F3_SLT     = 3'd2;
    localparam logic [2:0] F3_SLTU    = 3'd3;
    localparam logic [2:0] F3_XOR     = 3'd4;
    localparam logic [2:0] F3_SR      = 3'd5;
    localparam logic [2:0] F3_OR      = 3'd6;
    localparam logic [2:0] F3_AND     = 3'd7;

    // branch funct3 codes
    localparam logic [2:0] F3_BEQ     = 3'd0;
    localparam logic [2:0] F3_BNE     = 3'd1;
    localparam logic [2:0] F3_BLT     = 3'd4;
    localparam logic [2:0] F3_BGE     = 3'd5;
    localparam logic [2:0] F3_BLTU    = 3'd6;
    localparam logic [2:0] F3_BGEU    = 3'd7;

    // write-back value source
    typedef enum logic [2:0] {
        SEL_ZERO  = 3'd0,
        SEL_ALU   = 3'd1,
        SEL_ADDR  = 3'd2,
        SEL_PC4   = 3'd3,
        SEL_UPPER = 3'd4,
        SEL_AUIPC = 3'd5
    } res_sel_t;

    // next pc source
    typedef enum logic [1:0] {
        REDIR_NONE   = 2'd0,
        REDIR_BRANCH = 2'd1,
        REDIR_JUMP   = 2'd2,
        REDIR_JALR   = 2'd3
    } redir_t;

    typedef struct packed {
        logic [2:0]                 kind;
        logic                       jump_register;
        logic                       load_flag;
        logic                       op_immediate;
        logic                       load_upper;
        logic [2:0]                 funct_three;
        logic                       alternate_op;
        logic signed [IMM_BITS-1:0] immediate;
        logic [PC_BITS-1:0]         pc_value;
        logic signed [XLEN-1:0]     source_one;
        logic signed [XLEN-1:0]     source_two;
    } exec_in_t;

    typedef struct packed {
        logic signed [XLEN-1:0]     result_value;
        logic [PC_BITS-1:0]         next_pc;
        logic                       redirect;
    } exec_out_t;

endpackage

// ===== design/rv32i_execute_stage.sv =====
// rv32i_execute_stage: pipelined rv32i execute stage (alu, branch compare, next pc)
// depends on rv32ex_pkg for payload structs, format and funct3 codes

// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+-----------------------
// instr     | in        | instr_valid / instr_stall  | rv32ex_pkg::exec_in_t
// result    | out       | result_valid / result_stall| rv32ex_pkg::exec_out_t
//
// three register stages: decode/operand prep, alu and adders, result select
// result_valid rises once an instr transfer has passed the stage 1, stage 2 and output registers;
// one instruction per cycle while result_stall is low
// rst_n clears only the valid bits of the three stages, payload registers are not reset
// a stall on result holds the output register; bubbles inside the pipe still close up,
// so instr_stall rises only once every stage holds a waiting instruction

module rv32i_execute_stage #(
    parameter int CODE_ADDR_BITS = rv32ex_pkg::CODE_ADDR_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  instr_valid,
    output logic                  instr_stall,
    input  rv32ex_pkg::exec_in_t  instr,

    output logic                  result_valid,
    input  logic                  result_stall,
    output rv32ex_pkg::exec_out_t result
);

    // code address wrap mask, all ones when code addresses span the full word
    localparam logic [rv32ex_pkg::XLEN-1:0] CODE_MASK =
        (CODE_ADDR_BITS >= rv32ex_pkg::XLEN) ? {rv32ex_pkg::XLEN{1'b1}}
        : rv32ex_pkg::XLEN'((64'd1 << CODE_ADDR_BITS) - 64'd1);

    // stage 1: decoded controls and prepared operands
    typedef struct packed {
        rv32ex_pkg::res_sel_t              sel;
        rv32ex_pkg::redir_t                redir;
        logic [2:0]                        f3;
        logic                              alt;
        logic                              sub;
        logic [4:0]                        shamt;
        logic [rv32ex_pkg::XLEN-1:0]       a;
        logic [rv32ex_pkg::XLEN-1:0]       b;
        logic [rv32ex_pkg::XLEN-1:0]       imm;
        logic [rv32ex_pkg::XLEN-1:0]       pc;
    } s1_t;

    // stage 2: every candidate value, picked in stage 3
    typedef struct packed {
        rv32ex_pkg::res_sel_t              sel;
        rv32ex_pkg::redir_t                redir;
        logic                              taken;
        logic [rv32ex_pkg::XLEN-1:0]       alu_res;
        logic [rv32ex_pkg::XLEN-1:0]       addr_sum;
        logic [rv32ex_pkg::XLEN-1:0]       pc4;
        logic [rv32ex_pkg::XLEN-1:0]       jb_target;
        logic [rv32ex_pkg::XLEN-1:0]       jalr_target;
        logic [rv32ex_pkg::XLEN-1:0]       upper;
        logic [rv32ex_pkg::XLEN-1:0]       auipc;
    } s2_t;

    logic                  s1_valid_reg;
    logic                  s2_valid_reg;
    logic                  out_valid_reg;
    s1_t                   s1_reg;
    s1_t                   s1_next;
    s2_t                   s2_reg;
    s2_t                   s2_next;
    rv32ex_pkg::exec_out_t out_reg;
    rv32ex_pkg::exec_out_t out_next;

    logic                  s1_en;
    logic                  s2_en;
    logic                  out_en;

    // stage advance: a stage loads when empty or when its successor loads
    assign out_en      = !out_valid_reg || !result_stall;
    assign s2_en       = !s2_valid_reg || out_en;
    assign s1_en       = !s1_valid_reg || s2_en;
    assign instr_stall = !s1_en;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ---------------------------------------------------------------- stage 1
    // decode format and flags into a result source and a next pc source
    always_comb
    begin
        s1_next       = '0;
        s1_next.f3    = instr.funct_three;
        s1_next.alt   = instr.alternate_op;
        s1_next.a     = instr.source_one;
        s1_next.b     = instr.source_two;
        s1_next.imm   = {{(rv32ex_pkg::XLEN - rv32ex_pkg::IMM_BITS){instr.immediate[
                            rv32ex_pkg::IMM_BITS-1]}}, instr.immediate};
        s1_next.pc    = {{(rv32ex_pkg::XLEN - rv32ex_pkg::PC_BITS){1'b0}}, instr.pc_value};
        s1_next.sel   = rv32ex_pkg::SEL_ZERO;
        s1_next.redir = rv32ex_pkg::REDIR_NONE;
        s1_next.sub   = 1'b0;
        s1_next.shamt = instr.immediate[4:0];
        case (instr.kind)
            rv32ex_pkg::KIND_R:
            begin
                s1_next.sel   = rv32ex_pkg::SEL_ALU;
                s1_next.shamt = instr.source_two[4:0];
                // sub only for register-register add
                s1_next.sub   = instr.alternate_op
                                && (instr.funct_three == rv32ex_pkg::F3_ADD);
            end
            rv32ex_pkg::KIND_I:
            begin
                // jalr wins over load, load over op-imm
                if (instr.jump_register)
                begin
                    s1_next.sel   = rv32ex_pkg::SEL_PC4;
                    s1_next.redir = rv32ex_pkg::REDIR_JALR;
                end
                else if (instr.load_flag)
                begin
                    s1_next.sel = rv32ex_pkg::SEL_ADDR;
                end
                else if (instr.op_immediate)
                begin
                    s1_next.sel = rv32ex_pkg::SEL_ALU;
                end
            end
            rv32ex_pkg::KIND_S:
            begin
                s1_next.sel = rv32ex_pkg::SEL_ADDR;
            end
            rv32ex_pkg::KIND_B:
            begin
                s1_next.redir = rv32ex_pkg::REDIR_BRANCH;
            end
            rv32ex_pkg::KIND_U:
            begin
                s1_next.sel = instr.load_upper ? rv32ex_pkg::SEL_UPPER
                                               : rv32ex_pkg::SEL_AUIPC;
            end
            rv32ex_pkg::KIND_J:
            begin
                s1_next.sel   = rv32ex_pkg::SEL_PC4;
                s1_next.redir = rv32ex_pkg::REDIR_JUMP;
            end
            default:
            begin
                s1_next.sel   = rv32ex_pkg::SEL_ZERO;
                s1_next.redir = rv32ex_pkg::REDIR_NONE;
            end
        endcase
    end

    // ---------------------------------------------------------------- stage 2
    // alu, branch compare and all address adders run side by side
    logic [rv32ex_pkg::XLEN-1:0] b_op;
    logic [rv32ex_pkg::XLEN-1:0] add_sum;
    logic                        lt_signed;
    logic                        lt_unsigned;

    always_comb
    begin
        b_op        = s1_reg.sub ? ~s1_reg.b : s1_reg.b;
        add_sum     = s1_reg.a + b_op + {{(rv32ex_pkg::XLEN-1){1'b0}}, s1_reg.sub};
        lt_signed   = $signed(s1_reg.a) < $signed(s1_reg.b);
        lt_unsigned = s1_reg.a < s1_reg.b;

        s2_next       = '0;
        s2_next.sel   = s1_reg.sel;
        s2_next.redir = s1_reg.redir;

        case (s1_reg.f3)
            rv32ex_pkg::F3_ADD:  s2_next.alu_res = add_sum;
            rv32ex_pkg::F3_SLL:  s2_next.alu_res = s1_reg.a << s1_reg.shamt;
            rv32ex_pkg::F3_SLT:  s2_next.alu_res = {{(rv32ex_pkg::XLEN-1){1'b0}}, lt_signed};
            rv32ex_pkg::F3_SLTU: s2_next.alu_res = {{(rv32ex_pkg::XLEN-1){1'b0}}, lt_unsigned};
            rv32ex_pkg::F3_XOR:  s2_next.alu_res = s1_reg.a ^ s1_reg.b;
            rv32ex_pkg::F3_SR:
            begin
                if (s1_reg.alt)
                begin
                    s2_next.alu_res = $unsigned($signed(s1_reg.a) >>> s1_reg.shamt);
                end
                else
                begin
                    s2_next.alu_res = s1_reg.a >> s1_reg.shamt;
                end
            end
            rv32ex_pkg::F3_OR:   s2_next.alu_res = s1_reg.a | s1_reg.b;
            default:             s2_next.alu_res = s1_reg.a & s1_reg.b;
        endcase

        case (s1_reg.f3)
            rv32ex_pkg::F3_BEQ:  s2_next.taken = (s1_reg.a == s1_reg.b);
            rv32ex_pkg::F3_BNE:  s2_next.taken = (s1_reg.a != s1_reg.b);
            rv32ex_pkg::F3_BLT:  s2_next.taken = lt_signed;
            rv32ex_pkg::F3_BGE:  s2_next.taken = !lt_signed;
            rv32ex_pkg::F3_BLTU: s2_next.taken = lt_unsigned;
            rv32ex_pkg::F3_BGEU: s2_next.taken = !lt_unsigned;
            default:             s2_next.taken = 1'b0;
        endcase

        s2_next.addr_sum    = s1_reg.a + s1_reg.imm;
        s2_next.pc4         = (s1_reg.pc + rv32ex_pkg::INSTR_BYTES) & CODE_MASK;
        // branch and jal offsets are stored halved
        s2_next.jb_target   = (s1_reg.pc + {s1_reg.imm[rv32ex_pkg::XLEN-2:0], 1'b0})
                              & CODE_MASK;
        s2_next.jalr_target = (s1_reg.a + s1_reg.imm) & rv32ex_pkg::JALR_ALIGN_MASK
                              & CODE_MASK;
        s2_next.upper       = s1_reg.imm << rv32ex_pkg::UPPER_SHIFT;
        s2_next.auipc       = s1_reg.pc + (s1_reg.imm << rv32ex_pkg::UPPER_SHIFT);
    end

    // ---------------------------------------------------------------- stage 3
    // pick write-back value and next pc
    logic [rv32ex_pkg::XLEN-1:0] res_value;
    logic [rv32ex_pkg::XLEN-1:0] npc_value;
    logic                        redir_flag;

    always_comb
    begin
        case (s2_reg.sel)
            rv32ex_pkg::SEL_ALU:   res_value = s2_reg.alu_res;
            rv32ex_pkg::SEL_ADDR:  res_value = s2_reg.addr_sum;
            rv32ex_pkg::SEL_PC4:   res_value = s2_reg.pc4;
            rv32ex_pkg::SEL_UPPER: res_value = s2_reg.upper;
            rv32ex_pkg::SEL_AUIPC: res_value = s2_reg.auipc;
            default:               res_value = '0;
        endcase

        case (s2_reg.redir)
            rv32ex_pkg::REDIR_BRANCH:
            begin
                npc_value  = s2_reg.taken ? s2_reg.jb_target : s2_reg.pc4;
                redir_flag = s2_reg.taken;
            end
            rv32ex_pkg::REDIR_JUMP:
            begin
                npc_value  = s2_reg.jb_target;
                redir_flag = 1'b1;
            end
            rv32ex_pkg::REDIR_JALR:
            begin
                npc_value  = s2_reg.jalr_target;
                redir_flag = 1'b1;
            end
            default:
            begin
                npc_value  = s2_reg.pc4;
                redir_flag = 1'b0;
            end
        endcase

        out_next.result_value = $signed(res_value);
        out_next.next_pc      = npc_value[rv32ex_pkg::PC_BITS-1:0];
        out_next.redirect     = redir_flag;
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
            begin
                s1_valid_reg <= instr_valid;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_en)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en && instr_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_en && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
        if (out_en && s2_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

`ifndef SYNTHESIS
    // backpressure reaches the input only with stage 1 occupied
    a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        instr_stall |-> s1_valid_reg)
        else $error("instr_stall with empty stage 1");

    // a held stage 2 instruction keeps its contents
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_en) |=> (s2_valid_reg && $stable(s2_reg)))
        else $error("stage 2 contents changed while held");

    // no pc change unless the instruction is a branch or a jump
    a_no_redirect: assert property (@(posedge clk) disable iff (!rst_n)
        (out_en && s2_valid_reg && (s2_reg.redir == rv32ex_pkg::REDIR_NONE))
        |=> (!result.redirect
             && (result.next_pc == $past(s2_reg.pc4[rv32ex_pkg::PC_BITS-1:0]))))
        else $error("redirect or wrong next pc for sequential instruction");

    // a new result appears only after stage 2 held an instruction
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(s2_valid_reg))
        else $error("result_valid rose without a stage 2 instruction");
`endif

endmodule
